[design/windowed_range_obstacle_avoider_core_assert.svh]
// Assertion macros shared by the obstacle avoider RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef WINDOWED_RANGE_OBSTACLE_AVOIDER_CORE_ASSERT_SVH
`define WINDOWED_RANGE_OBSTACLE_AVOIDER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WROA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WROA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[design/wroa_pkg.sv]
// Shared types and constants of the windowed range obstacle avoider.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package wroa_pkg;

  localparam int WINDOW_LEN = 8;
  localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SENSORS    = 3;
  localparam int SENSOR_W   = 2;
  localparam int ADDR_W     = SENSOR_W + SLOT_W;
  localparam int MEM_DEPTH  = SENSORS << SLOT_W;
  localparam int SAMPLE_W   = 11;
  localparam int LIMIT_W    = 14;
  localparam int ACTION_W   = 2;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  // A sum of WINDOW_LEN samples in -1024..1023 never wraps at this width.
  localparam int SUM_W      = $clog2(WINDOW_LEN) + 12;
  localparam int CMP_W      = (SUM_W > LIMIT_W) ? SUM_W + 1 : LIMIT_W + 1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_RESET = SAMPLE_W'(100);
  localparam logic signed [SUM_W-1:0]    SUM_RESET    = SUM_W'(100 * WINDOW_LEN);
  localparam logic [LIMIT_W-1:0]         SIDE_RESET   = LIMIT_W'(240);
  localparam logic [LIMIT_W-1:0]         FRONT_RESET  = LIMIT_W'(320);

  // Action codes of an input item.
  localparam logic [ACTION_W-1:0] ACT_LEFT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CENTRE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RIGHT  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_LIMIT = 1'b1;

  // Command codes, two's complement.
  localparam logic signed [CMD_W-1:0] CMD_NEG  = 2'sb11;
  localparam logic signed [CMD_W-1:0] CMD_ZERO = 2'sb00;
  localparam logic signed [CMD_W-1:0] CMD_POS  = 2'sb01;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    sum_t left;
    sum_t centre;
    sum_t right;
  } wroa_sums_t;

  // Status of the item held in the update stage.
  typedef struct packed {
    logic valid;
    logic tick;
  } wroa_s2_t;

endpackage

[design/windowed_range_obstacle_avoider_core.sv]
// Top level of the windowed range obstacle avoider: channels, config, output register.
// Depends on wroa_pkg, wroa_ring, wroa_decide and the assertion macro header.
//
// Usage. Each input item carries an action and a sample. Actions left, centre
// and right push the sample into that sensor's window of the last WINDOW_LEN
// samples and update its running sum; they produce no result item. A decide
// tick compares the three sums with side_limit and front_limit and produces
// exactly one result item with the drive and turn commands.
// Throughput is one item per cycle while in_stall is low, set by the single
// read and write port of the ring memory: each item reads its entry on
// acceptance and writes it back in the next cycle, with the write forwarded to
// a following read of the same entry. A tick result passes from the update
// stage into the output register. While the receiver stalls, the result
// register holds its item and the input still accepts until a second tick is
// waiting behind it; then in_stall rises until the output is taken.
// Reset (rst_n low at a clock edge) loads the default limits, clears the
// slot pointers and sets each sum to 100 times the window length; the ring
// entries read as 100 until first written, so no clearing pass is needed and
// items are accepted right after reset. Configuration writes are taken in any
// cycle and should be issued only while the block is idle.
`timescale 1ns / 1ps
`include "windowed_range_obstacle_avoider_core_assert.svh"

module windowed_range_obstacle_avoider_core
  import wroa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ACTION_W-1:0]        in_action,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [CMD_W-1:0]    out_linear_cmd,
  output logic signed [CMD_W-1:0]    out_angular_cmd,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [LIMIT_W-1:0]         cfg_wdata
);

  logic [LIMIT_W-1:0]      side_limit_r;
  logic [LIMIT_W-1:0]      front_limit_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [CMD_W-1:0] lin_r, ang_r;
  logic signed [CMD_W-1:0] dec_lin, dec_ang;

  wroa_s2_t   s2;
  wroa_sums_t sums;
  logic       out_space;
  logic       fire;
  logic       adv;
  logic       acc;

  // The output register can load when it is empty or being emptied.
  assign out_space = !out_valid_r || !out_stall;
  // A tick leaves the update stage only into the output register; samples
  // always leave.
  assign fire      = s2.valid && s2.tick && out_space;
  assign adv       = s2.valid && (!s2.tick || out_space);
  assign in_stall  = s2.valid && !adv;
  assign acc       = in_valid && !in_stall;

  wroa_ring u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .action (in_action),
    .sample (in_sample),
    .adv    (adv),
    .s2     (s2),
    .sums   (sums)
  );

  wroa_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .sums        (sums),
    .side_limit  (side_limit_r),
    .front_limit (front_limit_r),
    .lin         (dec_lin),
    .ang         (dec_ang)
  );

  always_comb begin
    priority if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      side_limit_r  <= SIDE_RESET;
      front_limit_r <= FRONT_RESET;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIDE_LIMIT:  side_limit_r  <= cfg_wdata;
          REG_FRONT_LIMIT: front_limit_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lin_r <= dec_lin;
      ang_r <= dec_ang;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_linear_cmd  = lin_r;
  assign out_angular_cmd = ang_r;

  `WROA_ASSERT_NOW(a_stall_needs_full_out, clk, rst_n, in_stall, out_valid_r && s2.tick, "input stalled without a blocked tick")
  `WROA_ASSERT_NOW(a_result_from_tick, clk, rst_n, $rose(out_valid_r), $past(s2.valid && s2.tick), "result without a tick")
  `WROA_ASSERT_NEXT(a_sample_passes, clk, rst_n, s2.valid && !s2.tick, !s2.valid || $past(acc), "sample held in update stage")

endmodule

[design/wroa_ring.sv]
// Sample rings in one synchronous memory, slot pointers and running sums.
// Depends on wroa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "windowed_range_obstacle_avoider_core_assert.svh"

module wroa_ring
  import wroa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic [ACTION_W-1:0]        action,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       adv,
  output wroa_s2_t                   s2,
  output wroa_sums_t                 sums
);

  logic signed [SAMPLE_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]       vbit_r;
  logic [SLOT_W-1:0]          slot_r [SENSORS];
  sum_t                       sum_r  [SENSORS];

  logic                       s2_valid_r;
  logic                       s2_tick_r;
  logic [SENSOR_W-1:0]        s2_sensor_r;
  logic [ADDR_W-1:0]          s2_addr_r;
  logic signed [SAMPLE_W-1:0] s2_sample_r;
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic                       rd_vld_r;
  logic                       fwd_r;
  logic signed [SAMPLE_W-1:0] fwd_data_r;

  logic                       is_tick;
  logic [SENSOR_W-1:0]        sensor;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       wr_en;
  logic signed [SAMPLE_W-1:0] old_val;
  sum_t                       sum_nxt;

  assign is_tick = (action == ACT_TICK);
  assign sensor  = action;
  assign rd_addr = {sensor, slot_r[sensor]};
  assign wr_en   = s2_valid_r && !s2_tick_r && adv;

  // The entry leaving the window: a write made in the same cycle as its read is forwarded.
  assign old_val = fwd_r ? fwd_data_r : (rd_vld_r ? rd_data_r : SAMPLE_RESET);
  assign sum_nxt = sum_r[s2_sensor_r] - SUM_W'(old_val) + SUM_W'(s2_sample_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s2_addr_r] <= s2_sample_r;
    end
    if (acc && !is_tick) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s2_tick_r   <= is_tick;
      s2_sensor_r <= sensor;
      s2_addr_r   <= rd_addr;
      s2_sample_r <= sample;
      fwd_data_r  <= s2_sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      vbit_r     <= '0;
      rd_vld_r   <= 1'b0;
      fwd_r      <= 1'b0;
      for (int i = 0; i < SENSORS; i++) begin
        slot_r[i] <= '0;
        sum_r[i]  <= SUM_RESET;
      end
    end else begin
      if (acc) begin
        s2_valid_r <= 1'b1;
      end else if (adv) begin
        s2_valid_r <= 1'b0;
      end
      if (acc && !is_tick) begin
        rd_vld_r <= vbit_r[rd_addr];
        fwd_r    <= wr_en && (s2_addr_r == rd_addr);
        if (slot_r[sensor] == SLOT_W'(WINDOW_LEN - 1)) begin
          slot_r[sensor] <= '0;
        end else begin
          slot_r[sensor] <= slot_r[sensor] + 1'b1;
        end
      end
      if (wr_en) begin
        vbit_r[s2_addr_r]  <= 1'b1;
        sum_r[s2_sensor_r] <= sum_nxt;
      end
    end
  end

  assign s2.valid    = s2_valid_r;
  assign s2.tick     = s2_tick_r;
  assign sums.left   = sum_r[ACT_LEFT];
  assign sums.centre = sum_r[ACT_CENTRE];
  assign sums.right  = sum_r[ACT_RIGHT];

  `WROA_ASSERT_NEXT(a_acc_fills_s2, clk, rst_n, acc, s2_valid_r, "accepted item lost")
  `WROA_ASSERT_NOW(a_slots_in_range, clk, rst_n, 1'b1, (slot_r[0] <= SLOT_W'(WINDOW_LEN - 1)) && (slot_r[1] <= SLOT_W'(WINDOW_LEN - 1)) && (slot_r[2] <= SLOT_W'(WINDOW_LEN - 1)), "slot out of window")

endmodule

[design/wroa_decide.sv]
// Decision logic for a tick: limit compares, command choice, oscillation state.
// Depends on wroa_pkg.
`timescale 1ns / 1ps

module wroa_decide
  import wroa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  wroa_sums_t               sums,
  input  logic [LIMIT_W-1:0]       side_limit,
  input  logic [LIMIT_W-1:0]       front_limit,
  output logic signed [CMD_W-1:0]  lin,
  output logic signed [CMD_W-1:0]  ang
);

  logic                    osc_r, osc_nxt;
  logic signed [CMD_W-1:0] last_turn_r, last_turn_nxt;
  logic signed [CMD_W-1:0] prev_lin_r, prev_ang_r;
  logic signed [CMD_W-1:0] base_ang;
  logic signed [CMP_W-1:0] side_x, front_x, l_x, c_x, r_x;
  logic                    err, lc, cc, rc;

  assign side_x  = $signed({{(CMP_W - LIMIT_W){1'b0}}, side_limit});
  assign front_x = $signed({{(CMP_W - LIMIT_W){1'b0}}, front_limit});
  assign l_x     = CMP_W'(sums.left);
  assign c_x     = CMP_W'(sums.centre);
  assign r_x     = CMP_W'(sums.right);

  assign err = (sums.left == '1) || (sums.centre == '1) || (sums.right == '1);
  assign lc  = l_x < side_x;
  assign cc  = c_x < front_x;
  assign rc  = r_x < side_x;

  always_comb begin
    osc_nxt       = osc_r;
    last_turn_nxt = last_turn_r;
    lin           = CMD_ZERO;
    base_ang      = CMD_ZERO;
    priority if (err) begin
      lin      = CMD_ZERO;
      base_ang = CMD_ZERO;
    end else if (lc || cc || rc) begin
      osc_nxt = 1'b0;
      lin     = CMD_NEG;
      if (lc) begin
        lin           = CMD_ZERO;
        base_ang      = CMD_NEG;
        last_turn_nxt = CMD_NEG;
      end
      if (rc) begin
        lin           = CMD_ZERO;
        base_ang      = CMD_POS;
        last_turn_nxt = CMD_POS;
      end
      if ((lc && rc) || cc) begin
        lin      = CMD_NEG;
        base_ang = CMD_ZERO;
      end
    end else begin
      lin = CMD_POS;
      if ((prev_lin_r == CMD_NEG) && (prev_ang_r == CMD_ZERO)) begin
        osc_nxt = 1'b1;
      end
    end
    ang = osc_nxt ? last_turn_nxt : base_ang;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      osc_r       <= 1'b0;
      last_turn_r <= CMD_POS;
      prev_lin_r  <= CMD_ZERO;
      prev_ang_r  <= CMD_ZERO;
    end else if (fire) begin
      osc_r       <= osc_nxt;
      last_turn_r <= last_turn_nxt;
      prev_lin_r  <= lin;
      prev_ang_r  <= ang;
    end
  end

endmodule
